### rtl/tgd_pkg.sv
// Shared types and constants of the touch gesture decoder.
package tgd_pkg;

  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_TAP    = 4'd1,
    EV_LONG   = 4'd2,
    EV_LEFT   = 4'd3,
    EV_RIGHT  = 4'd4,
    EV_UP     = 4'd5,
    EV_DOWN   = 4'd6,
    EV_MULTI  = 4'd7,
    EV_TRIPLE = 4'd8
  } tgd_event_t;

  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_MULTITAP_CNT  = 3'd2;
  localparam logic [2:0] CFG_MULTITAP_WIN  = 3'd3;
  localparam logic [2:0] CFG_TAP_TIMEOUT   = 3'd4;
  localparam logic [2:0] CFG_LONGPRESS     = 3'd5;
  localparam logic [2:0] CFG_SWIPE_DELTA   = 3'd6;
  localparam logic [2:0] CFG_SWIPE_MAX     = 3'd7;

  localparam logic [7:0] TAP_SAT    = 8'd255;
  localparam logic [7:0] TAP_TRIPLE = 8'd3;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [7:0]  multitap_count;
    logic [31:0] multitap_window_ms;
    logic [31:0] tap_gap_ms;
    logic [31:0] hold_ms;
    logic [11:0] swipe_travel;
    logic [31:0] swipe_window_ms;
  } tgd_cfg_t;

  typedef struct packed {
    logic        pressed;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] now;
  } tgd_sample_t;

  typedef struct packed {
    logic        was_pressed;
    logic [31:0] press_start_time;
    logic        long_fired;
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [11:0] last_x;
    logic [11:0] last_y;
    logic [7:0]  tap_count;
    logic [31:0] first_tap_time;
    logic [31:0] last_tap_time;
    logic        triple_pending;
    logic [31:0] triple_due_time;
  } tgd_state_t;

endpackage

### rtl/touch_gesture_decoder.sv
// Touch gesture decoder: turns polled touch samples into one gesture event per sample.
//
// Input channel: one word per polled controller sample (count byte, X and Y bytes,
// millisecond timestamp) on in_valid/in_ready. Output channel: one gesture_event word
// per sample on out_valid/out_ready, in input order.
// The sample is registered at acceptance, with its press flag and screen bounds check
// already resolved. When the output register is free or drains, the decision logic
// updates the tracker state and loads the event into the output register. One sample
// per cycle is sustained while out_ready stays high; the input register and the
// output register each hold one word.
// When the receiver stalls, the output register holds its word and the input register
// holds the next sample; in_ready drops only when both are full.
// Reset clears the tracker state, empties both registers and loads the default
// configuration. Configuration writes on cfg_we take effect at once and are meant to
// happen only while no sample is in flight.
module touch_gesture_decoder
  import tgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  point_count_byte,
  input  logic [7:0]  x_high_byte,
  input  logic [7:0]  x_low_byte,
  input  logic [7:0]  y_high_byte,
  input  logic [7:0]  y_low_byte,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  gesture_event
);

  tgd_cfg_t    cfg;
  tgd_sample_t smp;
  tgd_sample_t smp_next;
  tgd_state_t  st;
  tgd_state_t  st_next;
  tgd_event_t  ev;
  logic        smp_valid;
  logic        advance;
  logic [11:0] in_x;
  logic [11:0] in_y;

  assign advance  = smp_valid && (!out_valid || out_ready);
  assign in_ready = !smp_valid || advance;

  assign in_x = {x_high_byte[3:0], x_low_byte};
  assign in_y = {y_high_byte[3:0], y_low_byte};

  // A touch outside the screen counts as no touch at all.
  always_comb begin
    smp_next.pressed = (point_count_byte[3:0] != 4'd0) &&
                       ({1'b0, in_x} < cfg.screen_width) &&
                       ({1'b0, in_y} < cfg.screen_height);
    smp_next.x   = in_x;
    smp_next.y   = in_y;
    smp_next.now = time_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width       <= 13'd466;
      cfg.screen_height      <= 13'd466;
      cfg.multitap_count     <= 8'd4;
      cfg.multitap_window_ms <= 32'd1000;
      cfg.tap_gap_ms         <= 32'd700;
      cfg.hold_ms            <= 32'd600;
      cfg.swipe_travel       <= 12'd30;
      cfg.swipe_window_ms    <= 32'd400;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  cfg.screen_width       <= cfg_data[12:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height      <= cfg_data[12:0];
        CFG_MULTITAP_CNT:  cfg.multitap_count     <= cfg_data[7:0];
        CFG_MULTITAP_WIN:  cfg.multitap_window_ms <= cfg_data;
        CFG_TAP_TIMEOUT:   cfg.tap_gap_ms         <= cfg_data;
        CFG_LONGPRESS:     cfg.hold_ms            <= cfg_data;
        CFG_SWIPE_DELTA:   cfg.swipe_travel       <= cfg_data[11:0];
        CFG_SWIPE_MAX:     cfg.swipe_window_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp <= smp_next;
    end
  end

  tgd_core u_core (
    .cfg     (cfg),
    .smp     (smp),
    .st      (st),
    .st_next (st_next),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture_event <= ev;
    end
  end

  a_triple_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && ev == EV_TRIPLE) |=> !st.triple_pending)
    else $error("triple tap fired but stayed pending");

  a_multi_resets_taps: assert property (@(posedge clk) disable iff (rst)
    (advance && ev == EV_MULTI) |=> (st.tap_count == 8'd0))
    else $error("multitap left taps counted");

  a_long_marks_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && ev == EV_LONG) |=> (st.long_fired && st.was_pressed))
    else $error("long press without a held touch");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule

### rtl/tgd_core.sv
// Per-sample gesture decision: next tracker state and event for one registered sample.
module tgd_core
  import tgd_pkg::*;
(
  input  tgd_cfg_t    cfg,
  input  tgd_sample_t smp,
  input  tgd_state_t  st,
  output tgd_state_t  st_next,
  output tgd_event_t  ev
);

  logic              trip_fire;
  logic              press_edge;
  logic              release_edge;
  logic [31:0]       held;
  logic [31:0]       held_eff;
  logic              long_eff;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic [11:0]       ax;
  logic [11:0]       ay;
  logic [7:0]        tc;
  logic [31:0]       first_t;
  logic [31:0]       since_first;
  logic [31:0]       since_last;
  logic              long_hit;

  assign trip_fire    = st.triple_pending && (smp.now >= st.triple_due_time);
  assign press_edge   = smp.pressed && !st.was_pressed;
  assign release_edge = !smp.pressed && st.was_pressed;
  assign held         = smp.now - st.press_start_time;
  // On the press edge the press start becomes now, so the hold time is zero.
  assign held_eff     = press_edge ? 32'd0 : held;
  assign long_eff     = press_edge ? 1'b0 : st.long_fired;

  assign dx = $signed({1'b0, st.last_x}) - $signed({1'b0, st.start_x});
  assign dy = $signed({1'b0, st.last_y}) - $signed({1'b0, st.start_y});
  assign ax = dx[12] ? 12'(-dx) : dx[11:0];
  assign ay = dy[12] ? 12'(-dy) : dy[11:0];

  assign tc          = (st.tap_count == TAP_SAT) ? TAP_SAT : st.tap_count + 8'd1;
  assign first_t     = (tc == 8'd1) ? smp.now : st.first_tap_time;
  assign since_first = (tc == 8'd1) ? 32'd0 : smp.now - st.first_tap_time;
  assign since_last  = smp.now - st.last_tap_time;

  always_comb begin
    st_next  = st;
    ev       = EV_NONE;
    long_hit = 1'b0;
    if (trip_fire) begin
      st_next.triple_pending = 1'b0;
      ev = EV_TRIPLE;
    end else if (release_edge) begin
      st_next.was_pressed = 1'b0;
      if (st.long_fired) begin
        ev = EV_NONE;
      end else if (held <= cfg.swipe_window_ms && ax > ay && ax >= cfg.swipe_travel) begin
        ev = dx[12] ? EV_LEFT : EV_RIGHT;
      end else if (held <= cfg.swipe_window_ms && ay > ax && ay >= cfg.swipe_travel) begin
        ev = dy[12] ? EV_UP : EV_DOWN;
      end else begin
        st_next.first_tap_time = first_t;
        st_next.last_tap_time  = smp.now;
        if (tc >= cfg.multitap_count && since_first <= cfg.multitap_window_ms) begin
          st_next.tap_count = 8'd0;
          ev = EV_MULTI;
        end else begin
          st_next.tap_count = tc;
          if (tc == TAP_TRIPLE && since_first <= cfg.tap_gap_ms) begin
            st_next.triple_pending  = 1'b1;
            st_next.triple_due_time = first_t + cfg.tap_gap_ms;
          end
        end
      end
    end else begin
      if (press_edge) begin
        st_next.press_start_time = smp.now;
        st_next.long_fired       = 1'b0;
        st_next.start_x          = smp.x;
        st_next.start_y          = smp.y;
      end
      if (smp.pressed) begin
        st_next.was_pressed = 1'b1;
        st_next.last_x      = smp.x;
        st_next.last_y      = smp.y;
        if (!long_eff && held_eff >= cfg.hold_ms) begin
          st_next.long_fired = 1'b1;
          st_next.tap_count  = 8'd0;
          ev       = EV_LONG;
          long_hit = 1'b1;
        end
      end
      if (!long_hit && st.tap_count != 8'd0 && since_last > cfg.tap_gap_ms) begin
        ev = (st.tap_count == 8'd1) ? EV_TAP : EV_NONE;
        st_next.tap_count = 8'd0;
      end
    end
  end

endmodule
